>>> rtl/core/xssl_pkg.sv
`timescale 1ns / 1ps

package xssl_pkg;

  localparam int LINE_MAX = 4096;
  localparam int POS_W    = $clog2(LINE_MAX + 1);
  localparam int RUN_W    = POS_W + 1;
  localparam int STATE_W  = 12;
  localparam int LS_W     = STATE_W + 1;
  localparam int STYLE_W  = 3;
  localparam int NRES     = 6;
  localparam int NSLOT    = NRES + 1;
  localparam int CNT_W    = $clog2(NSLOT + 1);

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [RUN_W-1:0]   run_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [STATE_W-1:0] lstate_t;
  typedef logic [STYLE_W-1:0] style_t;

  localparam run_t LINE_MAX_RUN = run_t'(LINE_MAX);
  localparam pos_t LINE_MAX_POS = pos_t'(LINE_MAX);
  localparam cnt_t NRES_CNT     = cnt_t'(NRES);

  localparam lstate_t LX_TEXT        = lstate_t'(0);
  localparam lstate_t LX_TAG_START   = lstate_t'(1);
  localparam lstate_t LX_TAG_NAME    = lstate_t'(2);
  localparam lstate_t LX_TAG_BODY    = lstate_t'(3);
  localparam lstate_t LX_DQUOTE      = lstate_t'(4);
  localparam lstate_t LX_SQUOTE      = lstate_t'(5);
  localparam lstate_t LX_ATTR        = lstate_t'(6);
  localparam lstate_t LX_ENTITY      = lstate_t'(7);
  localparam lstate_t LX_DECL        = lstate_t'(8);
  localparam lstate_t LX_COMMENT     = lstate_t'(9);
  localparam lstate_t LX_COMMENT_END = lstate_t'(10);

  localparam style_t SY_TEXT    = style_t'(0);
  localparam style_t SY_TAG     = style_t'(1);
  localparam style_t SY_KEYWORD = style_t'(2);
  localparam style_t SY_STRING  = style_t'(3);
  localparam style_t SY_ATTR    = style_t'(4);
  localparam style_t SY_ENTITY  = style_t'(5);
  localparam style_t SY_COMMENT = style_t'(6);

  typedef struct packed {
    logic [7:0]      ch;
    logic [7:0]      ahead;
    logic            first;
    logic [LS_W-1:0] start_state;
    logic            line_end;
  } item_t;

  typedef struct packed {
    lstate_t    lex_state;
    logic       close_flag;
    pos_t       run_start;
    pos_t       position;
    logic [7:0] prev0;
    logic [7:0] prev1;
    logic       skip_next;
    logic       line_done;
  } ctx_t;

  typedef struct packed {
    logic            valid;
    pos_t            offset;
    style_t          style;
    logic            is_mark;
    logic [LS_W-1:0] line_state;
  } res_t;

  typedef res_t [NRES-1:0] res_vec_t;

  typedef struct packed {
    logic     load;
    cnt_t     cnt;
    res_vec_t res;
  } batch_t;

endpackage

>>> rtl/core/xml_syntax_style_lexer_unit.sv
`timescale 1ns / 1ps

// Colours XML text one byte per request: each input request carries a byte, its
// lookahead byte and line framing, and the unit returns style marks and, when
// the line is left, a record of the packed line state (close flag in bit 12).
// A request enters an input register, is lexed there together with any byte
// that is handed back and the closing virtual byte at line end, and its
// results (up to six) are loaded into a result queue that delivers one result
// per cycle while the receiver is ready. A request that causes no result or
// one result then lets bytes stream at one per cycle; a request that causes
// more results holds the input until its last result goes out, as the queue
// must empty before the next request's results are loaded. Requests pass the
// input register and their results the queue register. Offsets saturate at 4096.
module xml_syntax_style_lexer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    ch,
  input  logic [7:0]                    ahead,
  input  logic                          first,
  input  logic [xssl_pkg::LS_W-1:0]     start_state,
  input  logic                          line_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [xssl_pkg::POS_W-1:0]    mark_offset,
  output logic [xssl_pkg::STYLE_W-1:0]  style,
  output logic                          is_mark,
  output logic [xssl_pkg::LS_W-1:0]     line_state,
  output logic                          final_res
);

  xssl_pkg::item_t    item_q;
  logic               in_full;
  logic               process;
  logic               can_load;
  xssl_pkg::ctx_t     ctx;
  xssl_pkg::ctx_t     ctx_next;
  xssl_pkg::res_vec_t step_res;
  xssl_pkg::cnt_t     step_cnt;
  xssl_pkg::batch_t   batch;
  xssl_pkg::res_t     head;

  assign process  = in_full && can_load;
  assign in_ready = !in_full || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (process) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.ch          <= ch;
      item_q.ahead       <= ahead;
      item_q.first       <= first;
      item_q.start_state <= start_state;
      item_q.line_end    <= line_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx <= '0;
    end else if (process) begin
      ctx <= ctx_next;
    end
  end

  xssl_step u_step (
    .cur  (ctx),
    .item (item_q),
    .nxt  (ctx_next),
    .res  (step_res),
    .cnt  (step_cnt)
  );

  assign batch = {process, step_cnt, step_res};

  xssl_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .batch     (batch),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .head      (head),
    .last      (final_res),
    .can_load  (can_load)
  );

  assign mark_offset = head.offset;
  assign style       = head.style;
  assign is_mark     = head.is_mark;
  assign line_state  = head.line_state;

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (process && ctx.line_done && !item_q.first) |=> (ctx == $past(ctx)))
    else $error("Lexer state moved on a byte after the line was left.");

  a_bad_state_leaves: assert property (@(posedge clk) disable iff (rst)
    (process && item_q.first &&
     item_q.start_state[xssl_pkg::STATE_W-1:0] > xssl_pkg::LX_COMMENT_END) |=> ctx.line_done)
    else $error("An unknown start state did not leave the line at once.");

  a_results_on_first: assert property (@(posedge clk) disable iff (rst)
    (process && item_q.first) |-> (step_cnt != '0))
    else $error("A line start request caused no text mark.");

endmodule

>>> rtl/core/xssl_step.sv
`timescale 1ns / 1ps

module xssl_step (
  input  xssl_pkg::ctx_t     cur,
  input  xssl_pkg::item_t    item,
  output xssl_pkg::ctx_t     nxt,
  output xssl_pkg::res_vec_t res,
  output xssl_pkg::cnt_t     cnt
);

  typedef struct packed {
    xssl_pkg::lstate_t lex_state;
    logic              close_flag;
    xssl_pkg::run_t    run;
    logic              skip;
  } lex_ctx_t;

  typedef struct packed {
    lex_ctx_t        cx;
    logic            again;
    logic            leave;
    xssl_pkg::res_t  mark;
  } pass_t;

  typedef struct packed {
    lex_ctx_t              cx;
    logic                  leave;
    xssl_pkg::res_t [2:0]  res;
  } lex_out_t;

  function automatic xssl_pkg::pos_t sat(input xssl_pkg::run_t x);
    if (x > xssl_pkg::LINE_MAX_RUN) begin
      return xssl_pkg::LINE_MAX_POS;
    end
    return x[xssl_pkg::POS_W-1:0];
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_name(input logic [7:0] c);
    return is_alpha(c) || (c >= "0" && c <= "9") || c == "-" || c == ":" || c == "_";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic xssl_pkg::res_t mk(input xssl_pkg::run_t s, input xssl_pkg::style_t sy);
    xssl_pkg::res_t r;
    r            = '0;
    r.valid      = 1'b1;
    r.offset     = sat(s);
    r.style      = sy;
    r.is_mark    = 1'b1;
    return r;
  endfunction

  function automatic xssl_pkg::res_t rec(input lex_ctx_t cx);
    xssl_pkg::res_t r;
    r            = '0;
    r.valid      = 1'b1;
    r.line_state = {cx.close_flag, cx.lex_state};
    return r;
  endfunction

  function automatic pass_t lex_pass(input lex_ctx_t cx, input logic [7:0] c,
                                     input logic [7:0] la, input xssl_pkg::run_t pos,
                                     input logic [7:0] prev0, input logic [7:0] prev1);
    pass_t p;
    logic  eol;
    p       = '0;
    p.cx    = cx;
    eol     = (c == 8'd0) || (c == "\n");
    unique case (cx.lex_state) inside
      xssl_pkg::LX_TEXT: begin
        p.cx.close_flag = 1'b0;
        if (c == "<") begin
          p.cx.lex_state = xssl_pkg::LX_TAG_START;
        end else if (c == "&") begin
          p.cx.lex_state = xssl_pkg::LX_ENTITY;
        end else if (eol) begin
          p.leave = 1'b1;
        end
        if ((p.leave || p.cx.lex_state != xssl_pkg::LX_TEXT) && cx.run <= pos) begin
          p.mark   = mk(cx.run, xssl_pkg::SY_TEXT);
          p.cx.run = pos;
        end
      end
      xssl_pkg::LX_TAG_START: begin
        if (is_alpha(c) || c == "/") begin
          p.cx.close_flag = (c == "/");
          p.mark          = mk(cx.run, xssl_pkg::SY_TAG);
          p.cx.run        = pos;
          p.cx.lex_state  = xssl_pkg::LX_TAG_NAME;
        end else if (c == "?") begin
          p.cx.lex_state = xssl_pkg::LX_TAG_START;
        end else if (c == "!") begin
          p.cx.lex_state = xssl_pkg::LX_DECL;
        end else if (eol) begin
          p.mark  = mk(cx.run, xssl_pkg::SY_TAG);
          p.leave = 1'b1;
        end else if (!is_space(c)) begin
          p.cx.lex_state = xssl_pkg::LX_TAG_BODY;
          p.again        = 1'b1;
        end
      end
      xssl_pkg::LX_TAG_NAME: begin
        if (!is_name(c)) begin
          p.mark          = mk(cx.run, xssl_pkg::SY_KEYWORD);
          p.cx.close_flag = 1'b0;
          p.cx.lex_state  = xssl_pkg::LX_TAG_BODY;
          p.cx.run        = pos;
          p.again         = 1'b1;
        end
      end
      xssl_pkg::LX_TAG_BODY: begin
        if (eol) begin
          p.mark  = mk(cx.run, xssl_pkg::SY_TAG);
          p.leave = 1'b1;
        end else if (c == ">") begin
          p.mark         = mk(cx.run, xssl_pkg::SY_TAG);
          p.cx.run       = pos + xssl_pkg::run_t'(1);
          p.cx.lex_state = xssl_pkg::LX_TEXT;
        end else if (c == "\"" || c == "'") begin
          p.mark         = mk(cx.run, xssl_pkg::SY_TAG);
          p.cx.run       = pos;
          p.cx.lex_state = (c == "\"") ? xssl_pkg::LX_DQUOTE : xssl_pkg::LX_SQUOTE;
        end else if (is_alpha(c)) begin
          p.mark         = mk(cx.run, xssl_pkg::SY_TAG);
          p.cx.run       = pos;
          p.cx.lex_state = xssl_pkg::LX_ATTR;
        end
      end
      xssl_pkg::LX_DQUOTE, xssl_pkg::LX_SQUOTE: begin
        if ((cx.lex_state == xssl_pkg::LX_DQUOTE && c == "\"") ||
            (cx.lex_state == xssl_pkg::LX_SQUOTE && c == "'")) begin
          p.mark         = mk(cx.run, xssl_pkg::SY_STRING);
          p.cx.run       = pos + xssl_pkg::run_t'(1);
          p.cx.lex_state = xssl_pkg::LX_TAG_BODY;
        end else if (eol) begin
          p.mark  = mk(cx.run, xssl_pkg::SY_STRING);
          p.leave = 1'b1;
        end
      end
      xssl_pkg::LX_ATTR: begin
        if (!is_name(c)) begin
          p.mark         = mk(cx.run, xssl_pkg::SY_ATTR);
          p.cx.run       = pos;
          p.cx.lex_state = xssl_pkg::LX_TAG_BODY;
          p.again        = 1'b1;
        end
      end
      xssl_pkg::LX_ENTITY: begin
        if (eol) begin
          p.mark         = mk(cx.run, xssl_pkg::SY_TEXT);
          p.cx.lex_state = xssl_pkg::LX_TEXT;
          p.leave        = 1'b1;
        end else if (c == ";") begin
          p.mark         = mk(cx.run, xssl_pkg::SY_ENTITY);
          p.cx.run       = pos + xssl_pkg::run_t'(1);
          p.cx.lex_state = xssl_pkg::LX_TEXT;
        end else if (is_space(c)) begin
          p.cx.lex_state = xssl_pkg::LX_TEXT;
        end
      end
      xssl_pkg::LX_DECL: begin
        if (c == "-" && la == "-" && pos == cx.run + xssl_pkg::run_t'(2) &&
            prev0 == "!" && prev1 == "<") begin
          p.mark         = mk(cx.run, xssl_pkg::SY_TAG);
          p.cx.run       = pos;
          p.cx.skip      = 1'b1;
          p.cx.lex_state = xssl_pkg::LX_COMMENT;
        end else if (c == ">") begin
          p.mark         = mk(cx.run, xssl_pkg::SY_TAG);
          p.cx.run       = pos + xssl_pkg::run_t'(1);
          p.cx.lex_state = xssl_pkg::LX_TEXT;
        end else if (eol) begin
          p.mark  = mk(cx.run, xssl_pkg::SY_TAG);
          p.leave = 1'b1;
        end
      end
      xssl_pkg::LX_COMMENT: begin
        if (c == "-" && la == "-") begin
          p.mark         = mk(cx.run, xssl_pkg::SY_COMMENT);
          p.cx.run       = pos + xssl_pkg::run_t'(2);
          p.cx.skip      = 1'b1;
          p.cx.lex_state = xssl_pkg::LX_COMMENT_END;
        end else if (eol) begin
          p.mark  = mk(cx.run, xssl_pkg::SY_COMMENT);
          p.leave = 1'b1;
        end
      end
      xssl_pkg::LX_COMMENT_END: begin
        if (c == ">") begin
          p.mark         = mk(cx.run, xssl_pkg::SY_TAG);
          p.cx.run       = pos + xssl_pkg::run_t'(1);
          p.cx.lex_state = xssl_pkg::LX_TEXT;
        end else if (eol) begin
          p.mark  = mk(cx.run, xssl_pkg::SY_TAG);
          p.leave = 1'b1;
        end
      end
      default: begin
        p.leave = 1'b1;
      end
    endcase
    return p;
  endfunction

  // A byte that is handed back is lexed once more; only the tag body state
  // can follow such a hand-back, and it never hands back again.
  function automatic lex_out_t lex_full(input lex_ctx_t cx, input logic [7:0] c,
                                        input logic [7:0] la, input xssl_pkg::run_t pos,
                                        input logic [7:0] prev0, input logic [7:0] prev1);
    pass_t    p1;
    pass_t    p2;
    lex_out_t o;
    p1       = lex_pass(cx, c, la, pos, prev0, prev1);
    p2       = lex_pass(p1.cx, c, la, pos, prev0, prev1);
    o        = '0;
    o.res[0] = p1.mark;
    if (p1.again && !p1.leave) begin
      o.cx     = p2.cx;
      o.leave  = p2.leave;
      o.res[1] = p2.mark;
    end else begin
      o.cx    = p1.cx;
      o.leave = p1.leave;
    end
    o.cx.run = {1'b0, sat(o.cx.run)};
    if (o.leave) begin
      o.res[2] = rec(o.cx);
    end
    return o;
  endfunction

  function automatic lex_ctx_t to_lex(input xssl_pkg::ctx_t c);
    lex_ctx_t l;
    l.lex_state  = c.lex_state;
    l.close_flag = c.close_flag;
    l.run        = {1'b0, c.run_start};
    l.skip       = 1'b0;
    return l;
  endfunction

  xssl_pkg::ctx_t                      c0;
  xssl_pkg::ctx_t                      c1;
  lex_out_t                            l1;
  lex_out_t                            l2;
  xssl_pkg::pos_t                      vpos;
  xssl_pkg::res_t [xssl_pkg::NSLOT-1:0] slot;

  always_comb begin
    c0   = cur;
    slot = '0;
    if (item.first) begin
      c0            = '0;
      c0.lex_state  = item.start_state[xssl_pkg::STATE_W-1:0];
      c0.close_flag = item.start_state[xssl_pkg::STATE_W];
      slot[0]       = mk('0, xssl_pkg::SY_TEXT);
    end

    l1 = lex_full(to_lex(c0), item.ch, item.ahead, xssl_pkg::run_t'(c0.position),
                  c0.prev0, c0.prev1);
    c1 = c0;
    if (c0.skip_next) begin
      c1.skip_next = 1'b0;
    end else begin
      c1.lex_state  = l1.cx.lex_state;
      c1.close_flag = l1.cx.close_flag;
      c1.run_start  = l1.cx.run[xssl_pkg::POS_W-1:0];
      c1.skip_next  = l1.cx.skip;
      c1.line_done  = l1.leave;
      slot[3:1]     = l1.res;
    end
    c1.prev1    = c0.prev0;
    c1.prev0    = item.ch;
    c1.position = sat(xssl_pkg::run_t'(c0.position) + xssl_pkg::run_t'(1));

    vpos = c1.position;
    if (c1.skip_next) begin
      vpos = sat(xssl_pkg::run_t'(c1.position) + xssl_pkg::run_t'(1));
    end
    l2  = lex_full(to_lex(c1), 8'd0, 8'd0, xssl_pkg::run_t'(vpos), c1.prev0, c1.prev1);
    nxt = c1;
    if (!c1.line_done && item.line_end) begin
      nxt.lex_state  = l2.cx.lex_state;
      nxt.close_flag = l2.cx.close_flag;
      nxt.run_start  = l2.cx.run[xssl_pkg::POS_W-1:0];
      nxt.skip_next  = l2.cx.skip;
      nxt.line_done  = l2.leave;
      slot[6:4]      = l2.res;
    end

    if (!item.first && cur.line_done) begin
      nxt  = cur;
      slot = '0;
    end
  end

  always_comb begin
    res = '0;
    cnt = '0;
    for (int j = 0; j < xssl_pkg::NSLOT; j++) begin
      if (slot[j].valid) begin
        if (cnt < xssl_pkg::NRES_CNT) begin
          res[cnt] = slot[j];
        end
        cnt = cnt + xssl_pkg::cnt_t'(1);
      end
    end
  end

endmodule

>>> rtl/core/xssl_resq.sv
`timescale 1ns / 1ps

module xssl_resq (
  input  logic              clk,
  input  logic              rst,
  input  xssl_pkg::batch_t  batch,
  input  logic              out_ready,
  output logic              out_valid,
  output xssl_pkg::res_t    head,
  output logic              last,
  output logic              can_load
);

  xssl_pkg::res_vec_t q;
  xssl_pkg::cnt_t     count;
  logic               pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign head      = q[0];
  assign last      = (count == xssl_pkg::cnt_t'(1));
  assign can_load  = (count == '0) || (last && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (batch.load) begin
      count <= batch.cnt;
    end else if (pop) begin
      count <= count - xssl_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (batch.load) begin
      q <= batch.res;
    end else if (pop) begin
      for (int i = 0; i < xssl_pkg::NRES - 1; i++) begin
        q[i] <= q[i + 1];
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= xssl_pkg::NRES_CNT)
    else $error("Result queue holds more entries than one request can cause.");

  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    batch.load |-> (count == '0 || (last && pop)))
    else $error("Results loaded over entries that are still waiting.");

  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    (pop && !batch.load) |=> (count == $past(count) - xssl_pkg::cnt_t'(1)))
    else $error("Result count did not step down after a delivery.");

endmodule

>>> tb/tb_xml_syntax_style_lexer_unit.sv
`timescale 1ns / 1ps

typedef logic [7:0] byte_q_t[$];

typedef struct {
  xssl_pkg::pos_t            offset;
  xssl_pkg::style_t          style;
  logic                      is_mark;
  logic [xssl_pkg::LS_W-1:0] line_state;
  logic                      final_res;
} style_rec_t;

class style_scoreboard;
  xssl_pkg::lstate_t lex_st;
  logic              close_f;
  int unsigned       run_st;
  int unsigned       pos_cnt;
  logic [7:0]        prev0;
  logic [7:0]        prev1;
  bit                skip_pend;
  bit                line_left;
  style_rec_t        step_q[$];
  style_rec_t        expected_q[$];
  int                errors;

  function new();
    lex_st    = xssl_pkg::LX_TEXT;
    close_f   = 1'b0;
    run_st    = 0;
    pos_cnt   = 0;
    prev0     = 8'h00;
    prev1     = 8'h00;
    skip_pend = 1'b0;
    line_left = 1'b0;
    errors    = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  task report(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function int unsigned clip(int unsigned x);
    return (x > xssl_pkg::LINE_MAX) ? xssl_pkg::LINE_MAX : x;
  endfunction

  function bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function bit is_name_ch(logic [7:0] c);
    return is_letter(c) || (c >= "0" && c <= "9") || c == "-" || c == ":" || c == "_";
  endfunction

  function bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function void emit(int unsigned off, xssl_pkg::style_t sty, logic mk,
                     logic [xssl_pkg::LS_W-1:0] ls);
    style_rec_t r;
    if (step_q.size() >= xssl_pkg::NRES) return;
    r.offset     = xssl_pkg::pos_t'(clip(off));
    r.style      = sty;
    r.is_mark    = mk;
    r.line_state = ls;
    r.final_res  = 1'b0;
    step_q.push_back(r);
  endfunction

  function void lex_byte(logic [7:0] c, logic [7:0] la, int unsigned p);
    int unsigned s;
    bit leave;
    bit again;
    bit eol;
    s     = run_st;
    leave = 1'b0;
    eol   = (c == 8'h00 || c == "\n");
    do begin
      again = 1'b0;
      case (lex_st) inside
        xssl_pkg::LX_TEXT: begin
          close_f = 1'b0;
          if (c == "<") lex_st = xssl_pkg::LX_TAG_START;
          else if (c == "&") lex_st = xssl_pkg::LX_ENTITY;
          else if (eol) leave = 1'b1;
          if ((leave || lex_st != xssl_pkg::LX_TEXT) && s <= p) begin
            emit(s, xssl_pkg::SY_TEXT, 1'b1, '0);
            s = p;
          end
        end
        xssl_pkg::LX_TAG_START: begin
          if (is_letter(c) || c == "/") begin
            close_f = (c == "/");
            emit(s, xssl_pkg::SY_TAG, 1'b1, '0);
            s = p;
            lex_st = xssl_pkg::LX_TAG_NAME;
          end else if (c == "?") begin
          end else if (c == "!") begin
            lex_st = xssl_pkg::LX_DECL;
          end else if (eol) begin
            emit(s, xssl_pkg::SY_TAG, 1'b1, '0);
            leave = 1'b1;
          end else if (!is_blank(c)) begin
            lex_st = xssl_pkg::LX_TAG_BODY;
            again = 1'b1;
          end
        end
        xssl_pkg::LX_TAG_NAME: begin
          if (!is_name_ch(c)) begin
            emit(s, xssl_pkg::SY_KEYWORD, 1'b1, '0);
            close_f = 1'b0;
            lex_st = xssl_pkg::LX_TAG_BODY;
            s = p;
            again = 1'b1;
          end
        end
        xssl_pkg::LX_TAG_BODY: begin
          if (eol) begin
            emit(s, xssl_pkg::SY_TAG, 1'b1, '0);
            leave = 1'b1;
          end else if (c == ">") begin
            emit(s, xssl_pkg::SY_TAG, 1'b1, '0);
            s = p + 1;
            lex_st = xssl_pkg::LX_TEXT;
          end else if (c == "\"" || c == "'") begin
            emit(s, xssl_pkg::SY_TAG, 1'b1, '0);
            s = p;
            lex_st = (c == "\"") ? xssl_pkg::LX_DQUOTE : xssl_pkg::LX_SQUOTE;
          end else if (is_letter(c)) begin
            emit(s, xssl_pkg::SY_TAG, 1'b1, '0);
            s = p;
            lex_st = xssl_pkg::LX_ATTR;
          end
        end
        xssl_pkg::LX_DQUOTE, xssl_pkg::LX_SQUOTE: begin
          if ((lex_st == xssl_pkg::LX_DQUOTE && c == "\"") ||
              (lex_st == xssl_pkg::LX_SQUOTE && c == "'")) begin
            emit(s, xssl_pkg::SY_STRING, 1'b1, '0);
            s = p + 1;
            lex_st = xssl_pkg::LX_TAG_BODY;
          end else if (eol) begin
            emit(s, xssl_pkg::SY_STRING, 1'b1, '0);
            leave = 1'b1;
          end
        end
        xssl_pkg::LX_ATTR: begin
          if (!is_name_ch(c)) begin
            emit(s, xssl_pkg::SY_ATTR, 1'b1, '0);
            s = p;
            lex_st = xssl_pkg::LX_TAG_BODY;
            again = 1'b1;
          end
        end
        xssl_pkg::LX_ENTITY: begin
          if (eol) begin
            emit(s, xssl_pkg::SY_TEXT, 1'b1, '0);
            lex_st = xssl_pkg::LX_TEXT;
            leave = 1'b1;
          end else if (c == ";") begin
            emit(s, xssl_pkg::SY_ENTITY, 1'b1, '0);
            s = p + 1;
            lex_st = xssl_pkg::LX_TEXT;
          end else if (is_blank(c)) begin
            lex_st = xssl_pkg::LX_TEXT;
          end
        end
        xssl_pkg::LX_DECL: begin
          if (c == "-" && la == "-" && p == s + 2 && prev0 == "!" && prev1 == "<") begin
            emit(s, xssl_pkg::SY_TAG, 1'b1, '0);
            s = p;
            skip_pend = 1'b1;
            lex_st = xssl_pkg::LX_COMMENT;
          end else if (c == ">") begin
            emit(s, xssl_pkg::SY_TAG, 1'b1, '0);
            s = p + 1;
            lex_st = xssl_pkg::LX_TEXT;
          end else if (eol) begin
            emit(s, xssl_pkg::SY_TAG, 1'b1, '0);
            leave = 1'b1;
          end
        end
        xssl_pkg::LX_COMMENT: begin
          if (c == "-" && la == "-") begin
            emit(s, xssl_pkg::SY_COMMENT, 1'b1, '0);
            s = p + 2;
            skip_pend = 1'b1;
            lex_st = xssl_pkg::LX_COMMENT_END;
          end else if (eol) begin
            emit(s, xssl_pkg::SY_COMMENT, 1'b1, '0);
            leave = 1'b1;
          end
        end
        xssl_pkg::LX_COMMENT_END: begin
          if (c == ">") begin
            emit(s, xssl_pkg::SY_TAG, 1'b1, '0);
            s = p + 1;
            lex_st = xssl_pkg::LX_TEXT;
          end else if (eol) begin
            emit(s, xssl_pkg::SY_TAG, 1'b1, '0);
            leave = 1'b1;
          end
        end
        default: leave = 1'b1;
      endcase
    end while (again && !leave);
    run_st = clip(s);
    if (leave) begin
      emit(0, xssl_pkg::SY_TEXT, 1'b0, {close_f, lex_st});
      line_left = 1'b1;
    end
  endfunction

  function void note_request(logic [7:0] c, logic [7:0] la, logic fst,
                             logic [xssl_pkg::LS_W-1:0] st, logic lend);
    int unsigned p;
    int unsigned vp;
    style_rec_t  r;
    step_q.delete();
    if (fst) begin
      lex_st    = st[xssl_pkg::STATE_W-1:0];
      close_f   = st[xssl_pkg::LS_W-1];
      run_st    = 0;
      pos_cnt   = 0;
      prev0     = 8'h00;
      prev1     = 8'h00;
      skip_pend = 1'b0;
      line_left = 1'b0;
      emit(0, xssl_pkg::SY_TEXT, 1'b1, '0);
    end else if (line_left) begin
      return;
    end
    p = pos_cnt;
    if (skip_pend) skip_pend = 1'b0;
    else lex_byte(c, la, p);
    prev1   = prev0;
    prev0   = c;
    pos_cnt = clip(p + 1);
    if (!line_left && lend) begin
      vp = pos_cnt;
      if (skip_pend) begin
        skip_pend = 1'b0;
        vp = clip(vp + 1);
      end
      lex_byte(8'h00, 8'h00, vp);
    end
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.final_res = 1'b1;
      step_q.push_back(r);
    end
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  task check_result(xssl_pkg::pos_t off, xssl_pkg::style_t sty, logic mk,
                    logic [xssl_pkg::LS_W-1:0] ls, logic fin);
    style_rec_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result off=%0d style=%0d mark=%b state=%h final=%b",
                       off, sty, mk, ls, fin));
      return;
    end
    e = expected_q.pop_front();
    if (off !== e.offset || sty !== e.style || mk !== e.is_mark ||
        ls !== e.line_state || fin !== e.final_res)
      report($sformatf("got off=%0d style=%0d mark=%b state=%h final=%b, exp %0d %0d %b %h %b",
                       off, sty, mk, ls, fin, e.offset, e.style, e.is_mark,
                       e.line_state, e.final_res));
  endtask
endclass

module tb_xml_syntax_style_lexer_unit;
  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [7:0]                   ch = 8'h00;
  logic [7:0]                   ahead = 8'h00;
  logic                         first = 1'b0;
  logic [xssl_pkg::LS_W-1:0]    start_state = '0;
  logic                         line_end = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [xssl_pkg::POS_W-1:0]   mark_offset;
  logic [xssl_pkg::STYLE_W-1:0] style;
  logic                         is_mark;
  logic [xssl_pkg::LS_W-1:0]    line_state;
  logic                         final_res;

  style_scoreboard sb;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int sent = 0;

  xml_syntax_style_lexer_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ch          (ch),
    .ahead       (ahead),
    .first       (first),
    .start_state (start_state),
    .line_end    (line_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mark_offset (mark_offset),
    .style       (style),
    .is_mark     (is_mark),
    .line_state  (line_state),
    .final_res   (final_res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_result(mark_offset, style, is_mark, line_state, final_res);
      if (in_valid && in_ready)
        sb.note_request(ch, ahead, first, start_state, line_end);
    end
  end

  // The receiver holds off once for a long stretch so that the block backs up.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  task automatic send_item(logic [7:0] c, logic [7:0] la, logic fst,
                           logic [xssl_pkg::LS_W-1:0] st, logic lend);
    while (!calm && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    ch          <= c;
    ahead       <= la;
    first       <= fst;
    start_state <= st;
    line_end    <= lend;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_line(byte_q_t txt, logic [xssl_pkg::LS_W-1:0] st, bit with_end,
                           bit noisy);
    logic [7:0] la;
    for (int i = 0; i < txt.size(); i++) begin
      la = (i + 1 < txt.size()) ? txt[i+1] : 8'h00;
      if (noisy && $urandom_range(0, 9) == 0) la = 8'($urandom_range(0, 255));
      send_item(txt[i], la, i == 0, st, with_end && (i == txt.size() - 1));
      sent++;
    end
  endtask

  function automatic byte_q_t to_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic string rand_word(string alphabet, int lo, int hi);
    string s;
    int n;
    s = "";
    n = $urandom_range(lo, hi);
    for (int i = 0; i < n; i++)
      s = $sformatf("%s%c", s, alphabet[$urandom_range(0, alphabet.len() - 1)]);
    return s;
  endfunction

  function automatic string rand_name();
    string s;
    s = $sformatf("%c", 8'h61 + 8'($urandom_range(0, 25)));
    return {s, rand_word("abXYz09-:_", 0, 4)};
  endfunction

  function automatic string rand_piece();
    string n;
    string a;
    string v;
    n = rand_name();
    a = rand_name();
    v = rand_word("ab c<>&;-", 0, 4);
    case ($urandom_range(0, 11))
      0:  return rand_word("abc xyz 019\t", 1, 6);
      1:  return $sformatf("<%s>", n);
      2:  return $sformatf("</%s>", n);
      3:  return $sformatf("<%s %s=\"%s\">", n, a, v);
      4:  return $sformatf("<%s %s='%s'/>", n, a, v);
      5:  return $sformatf("<!--%s-->", rand_word("ab -", 0, 5));
      6:  return $sformatf("<?%s %s?>", n, a);
      7:  return $sformatf("<!%s %s>", n, a);
      8:  return $sformatf("&%s;", n);
      9:  return $sformatf("&%s ", n);
      10: return $sformatf("< %s %s", n, a);
      default: return $sformatf("<!--%s", rand_word("a->", 0, 5));
    endcase
  endfunction

  function automatic byte_q_t rand_xml();
    string s;
    int n;
    s = "";
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) s = {s, rand_piece()};
    return to_bytes(s);
  endfunction

  initial begin
    byte_q_t                   q;
    logic [xssl_pkg::LS_W-1:0] st;
    int                        idx;
    int                        waited;
    bit                        pressured;
    sb = new();
    pressured = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_line(to_bytes("<!--x-->"), {1'b0, xssl_pkg::LX_TEXT}, 1'b1, 1'b0);
    send_line(to_bytes("<a b=\"c\">&e;"), {1'b0, xssl_pkg::LX_TEXT}, 1'b1, 1'b0);
    send_item(8'hFF, 8'h00, 1'b1, '1, 1'b1);
    send_item("-", "-", 1'b1, {1'b1, xssl_pkg::LX_COMMENT}, 1'b1);
    send_item(8'h00, 8'hFF, 1'b1, {1'b0, xssl_pkg::LX_TEXT}, 1'b0);
    send_item(8'hFF, 8'h00, 1'b0, {1'b0, xssl_pkg::LX_TEXT}, 1'b1);
    sent = 0;

    while (sent < 220) begin
      calm = (sent >= 60 && sent < 110);
      if (!pressured && sent >= 60) begin
        hold_req  = 1'b1;
        pressured = 1'b1;
      end
      st = xssl_pkg::LS_W'($urandom_range(0, 10));
      if ($urandom_range(0, 4) == 0) st[xssl_pkg::LS_W-1] = 1'b1;
      if ($urandom_range(0, 3) == 0) st = {1'b0, xssl_pkg::LX_TEXT};
      case ($urandom_range(0, 19)) inside
        0, 1, 2: begin
          q.delete();
          for (int i = 0; i < $urandom_range(1, 8); i++) q.push_back(8'($urandom_range(0, 255)));
          send_line(q, xssl_pkg::LS_W'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)),
                    1'b1);
        end
        3, 4: begin
          q = rand_xml();
          idx = $urandom_range(0, q.size() - 1);
          case ($urandom_range(0, 2))
            0: q[idx] = 8'h00;
            1: q[idx] = "\n";
            default: q[idx] = 8'($urandom_range(0, 255));
          endcase
          send_line(q, st, 1'($urandom_range(0, 1)), 1'b0);
          for (int i = 0; i < $urandom_range(0, 2); i++)
            send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0,
                      xssl_pkg::LS_W'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)));
        end
        default: send_line(rand_xml(), st, $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0);
      endcase
    end
    calm = 1'b0;

    q = to_bytes("<b c='d'>&e;<!--f-->");
    send_line(q, {1'b0, xssl_pkg::LX_TEXT}, 1'b1, 1'b0);
    in_valid <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/core/xssl_pkg.sv
rtl/core/xssl_step.sv
rtl/core/xssl_resq.sv
rtl/core/xml_syntax_style_lexer_unit.sv
tb/tb_xml_syntax_style_lexer_unit.sv
